@@ design/rgblab_pkg.sv @@
`timescale 1ns / 1ps

package rgblab_pkg;

    // Tristimulus values are unsigned Q8.16, roots unsigned Q4.16.
    localparam int TRI_W  = 24;
    localparam int ROOT_W = 20;
    localparam int LIN_W  = 14;
    localparam int LLIN_W = 20;
    localparam int L16_W  = 26;

    // RGB to XYZ matrix in Q0.16, white point folded into the X and Z rows.
    localparam logic [15:0] MAT [3][3] = '{
        '{16'd28445, 16'd24656, 16'd12441},
        '{16'd13938, 16'd46869, 16'd4730},
        '{16'd1164,  16'd7175,  16'd57198}
    };

    localparam logic [TRI_W-1:0] THRESH     = 24'd580;
    localparam logic [18:0]      LIN_SLOPE  = 19'd510330;
    localparam logic [LIN_W-1:0] LIN_OFFSET = 14'd9039;
    localparam logic [25:0]      KAPPA      = 26'd59198669;

    // floor(u / 100) = (u * DIV100_MUL) >> DIV100_SHIFT for u below 2^18
    localparam logic [18:0]      DIV100_MUL   = 19'd335545;
    localparam int               DIV100_SHIFT = 25;

    typedef logic [2:0][TRI_W-1:0]  t_tri;
    typedef logic [2:0][ROOT_W-1:0] t_root;

    // Per-item data that rides alongside the cube root pipeline.
    typedef struct packed {
        logic [2:0]                  above;
        logic [2:0][LIN_W-1:0]       lin;
        logic [LLIN_W-1:0]           l_lin;
    } t_side;

    localparam int SIDE_W = $bits(t_side);

endpackage

@@ design/rgblab_pix_if.sv @@
`timescale 1ns / 1ps

interface rgblab_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ design/rgblab_lab_if.sv @@
`timescale 1ns / 1ps

interface rgblab_lab_if;
    logic               valid;
    logic               ready;
    logic [10:0]        lightness;
    logic signed [11:0] green_red;
    logic signed [10:0] blue_yellow;

    modport source (output valid, output lightness, output green_red, output blue_yellow,
                    input ready);
    modport sink   (input valid, input lightness, input green_red, input blue_yellow,
                    output ready);
endinterface

@@ design/rgb_to_cielab_convert_unit.sv @@
`timescale 1ns / 1ps
// RGB to CIE Lab converter, fully pipelined.
// Pipeline: 24 register stages (1 matrix stage, 20 cube root stages at one root bit each,
// 3 scaling stages). Throughput: one pixel per cycle while o_lab.ready does not stall the
// output; each stage holds independently, so bubbles collapse.
// Reset clears only the stage valid bits; payload registers are not reset.

module rgb_to_cielab_convert_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rgblab_pix_if.sink   i_pix,
    rgblab_lab_if.source o_lab
);

    localparam int SB_W   = rgblab_pkg::SIDE_W;
    localparam int TRI_W  = rgblab_pkg::TRI_W;
    localparam int ROOT_W = rgblab_pkg::ROOT_W;
    localparam int LIN_W  = rgblab_pkg::LIN_W;
    localparam int L16_W  = rgblab_pkg::L16_W;
    localparam int D_W    = ROOT_W + 1;      // signed difference of two f values
    localparam int P_W    = D_W + 10;        // times 500 or 200
    localparam int U_W    = 18;              // L * 255 in whole Q16 units
    localparam int Q_W    = U_W + 19;
    localparam int DIV100_SH = rgblab_pkg::DIV100_SHIFT;

    // ------------------------------------------------------------------
    // Handshake: each stage may load when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic en_s0, en_p1, en_p2, en_p3;
    logic cb_ready, cb_valid;

    logic r_v0, r_vp1, r_vp2, r_vp3;

    assign en_p3       = !r_vp3 || o_lab.ready;
    assign en_p2       = !r_vp2 || en_p3;
    assign en_p1       = !r_vp1 || en_p2;
    assign en_s0       = !r_v0 || cb_ready;
    assign i_pix.ready = en_s0;

    // ------------------------------------------------------------------
    // Stage 0: 3x3 matrix into X, Y, Z (Q8.16, never above 24 bits).
    // ------------------------------------------------------------------
    rgblab_pkg::t_tri n_t, r_t;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i] = TRI_W'(rgblab_pkg::MAT[i][0]) * TRI_W'(i_pix.red)
                   + TRI_W'(rgblab_pkg::MAT[i][1]) * TRI_W'(i_pix.green)
                   + TRI_W'(rgblab_pkg::MAT[i][2]) * TRI_W'(i_pix.blue);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en_s0) begin
            r_v0 <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s0) begin
            r_t <= n_t;
        end
    end

    // ------------------------------------------------------------------
    // Linear-segment values, worked out now and carried beside the roots.
    // They only matter when the value is at or below the threshold, i.e.
    // fits in 10 bits, so only the low 10 bits enter the products.
    // ------------------------------------------------------------------
    rgblab_pkg::t_side n_side;
    logic [28:0]       lin_prod [3];
    logic [35:0]       kap_prod;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lin_prod[i]     = 29'(rgblab_pkg::LIN_SLOPE) * 29'(r_t[i][9:0]);
            n_side.above[i] = r_t[i] > rgblab_pkg::THRESH;
            n_side.lin[i]   = LIN_W'(lin_prod[i][28:16]) + rgblab_pkg::LIN_OFFSET;
        end
        kap_prod     = 36'(rgblab_pkg::KAPPA) * 36'(r_t[1][9:0]);
        n_side.l_lin = kap_prod[35:16];
    end

    // ------------------------------------------------------------------
    // Cube roots of X, Y, Z: 20 stages, one root bit per stage.
    // ------------------------------------------------------------------
    rgblab_pkg::t_root cb_root;
    logic [SB_W-1:0]   cb_sb;
    rgblab_pkg::t_side cb_side;

    rgblab_cbrt3 #(
        .SB_W (SB_W)
    ) u_cbrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .o_ready (cb_ready),
        .i_val   (r_t),
        .i_sb    (SB_W'(n_side)),
        .o_valid (cb_valid),
        .i_ready (en_p1),
        .o_root  (cb_root),
        .o_sb    (cb_sb)
    );

    assign cb_side = rgblab_pkg::t_side'(cb_sb);

    // ------------------------------------------------------------------
    // P1: pick root or linear segment; form fx-fy, fy-fz and L in Q16.
    // Above the threshold fy is at least about 0.207, so 116*fy - 16
    // stays positive and L needs no clamp at zero.
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0]       f_sel [3];
    logic [L16_W:0]          l_hi;
    logic signed [D_W-1:0]   n_dxy, n_dyz, r_dxy, r_dyz;
    logic [L16_W-1:0]        n_l16, r_l16;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            f_sel[i] = cb_side.above[i] ? cb_root[i] : ROOT_W'(cb_side.lin[i]);
        end
        n_dxy = $signed({1'b0, f_sel[0]}) - $signed({1'b0, f_sel[1]});
        n_dyz = $signed({1'b0, f_sel[1]}) - $signed({1'b0, f_sel[2]});
        l_hi  = (L16_W+1)'(116) * (L16_W+1)'(f_sel[1]) - (L16_W+1)'(1 << 20);
        n_l16 = cb_side.above[1] ? l_hi[L16_W-1:0] : L16_W'(cb_side.l_lin);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp1 <= 1'b0;
        end else if (en_p1) begin
            r_vp1 <= cb_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p1) begin
            r_dxy <= n_dxy;
            r_dyz <= n_dyz;
            r_l16 <= n_l16;
        end
    end

    // ------------------------------------------------------------------
    // P2: scale by 500, 200 and 255; drop the Q16 fraction of L*255 now,
    // which leaves the same floor once divided by 100 later.
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] n_pa, n_pb, r_pa, r_pb;
    logic [L16_W+7:0]      l_prod;
    logic [U_W-1:0]        n_u, r_u;

    always_comb begin
        n_pa   = P_W'(r_dxy) * P_W'(500);
        n_pb   = P_W'(r_dyz) * P_W'(200);
        l_prod = (L16_W+8)'(r_l16) * (L16_W+8)'(255);
        n_u    = U_W'(l_prod[L16_W+7:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp2 <= 1'b0;
        end else if (en_p2) begin
            r_vp2 <= r_vp1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p2) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_u  <= n_u;
        end
    end

    // ------------------------------------------------------------------
    // P3: divide by 65536 toward zero, divide L by 100 with a reciprocal,
    // saturate each field.
    // ------------------------------------------------------------------
    logic signed [P_W-1:0] a_q, b_q;
    logic [Q_W-1:0]        q_prod;
    logic [Q_W-DIV100_SH-1:0] l_q;
    logic [10:0]           n_l, r_l;
    logic signed [11:0]    n_a, r_a;
    logic signed [10:0]    n_b, r_b;

    always_comb begin
        // Bias negatives so the arithmetic shift truncates toward zero.
        a_q = r_pa[P_W-1] ? ((r_pa + P_W'(65535)) >>> 16) : (r_pa >>> 16);
        b_q = r_pb[P_W-1] ? ((r_pb + P_W'(65535)) >>> 16) : (r_pb >>> 16);

        if (a_q > P_W'(2047)) begin
            n_a = 12'sd2047;
        end else if (a_q < -P_W'(2048)) begin
            n_a = -12'sd2048;
        end else begin
            n_a = 12'(a_q);
        end

        if (b_q > P_W'(1023)) begin
            n_b = 11'sd1023;
        end else if (b_q < -P_W'(1024)) begin
            n_b = -11'sd1024;
        end else begin
            n_b = 11'(b_q);
        end

        q_prod = Q_W'(r_u) * Q_W'(rgblab_pkg::DIV100_MUL);
        l_q    = q_prod[Q_W-1:DIV100_SH];
        n_l    = (l_q > (Q_W-DIV100_SH)'(2047)) ? 11'd2047 : 11'(l_q);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp3 <= 1'b0;
        end else if (en_p3) begin
            r_vp3 <= r_vp2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p3) begin
            r_l <= n_l;
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_lab.valid       = r_vp3;
    assign o_lab.lightness   = r_l;
    assign o_lab.green_red   = r_a;
    assign o_lab.blue_yellow = r_b;

endmodule

@@ design/rgblab_cbrt3.sv @@
`timescale 1ns / 1ps

// Three-lane floor(cbrt(v * 2^32)), one result bit per stage.
module rgblab_cbrt3 #(
    parameter int SB_W = rgblab_pkg::SIDE_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rgblab_pkg::t_tri    i_val,
    input  logic [SB_W-1:0]     i_sb,
    output logic                o_valid,
    input  logic                i_ready,
    output rgblab_pkg::t_root   o_root,
    output logic [SB_W-1:0]     o_sb
);

    localparam int STEPS = rgblab_pkg::ROOT_W;
    localparam int TRI_W = rgblab_pkg::TRI_W;
    localparam int N_W   = 3 * STEPS;
    localparam int Y2_W  = 2 * STEPS;
    localparam int REM_W = Y2_W + 2;
    localparam int RS_W  = REM_W + 3;

    logic                          r_vld [STEPS];
    rgblab_pkg::t_tri              r_src [STEPS];
    logic [2:0][STEPS-1:0]         r_y   [STEPS];
    logic [2:0][Y2_W-1:0]          r_y2  [STEPS];
    logic [2:0][REM_W-1:0]         r_rem [STEPS];
    logic [SB_W-1:0]               r_sb  [STEPS];
    logic                          en    [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam int HI = N_W - 1 - 3 * k;

        rgblab_pkg::t_tri      a_src;
        logic [2:0][STEPS-1:0] a_y;
        logic [2:0][Y2_W-1:0]  a_y2;
        logic [2:0][REM_W-1:0] a_rem;
        logic [SB_W-1:0]       a_sb;
        logic                  a_vld;
        logic [2:0][STEPS-1:0] n_y;
        logic [2:0][Y2_W-1:0]  n_y2;
        logic [2:0][REM_W-1:0] n_rem;

        if (k == 0) begin : g_first
            assign a_src = i_val;
            assign a_y   = '0;
            assign a_y2  = '0;
            assign a_rem = '0;
            assign a_sb  = i_sb;
            assign a_vld = i_valid;
        end else begin : g_next
            assign a_src = r_src[k-1];
            assign a_y   = r_y[k-1];
            assign a_y2  = r_y2[k-1];
            assign a_rem = r_rem[k-1];
            assign a_sb  = r_sb[k-1];
            assign a_vld = r_vld[k-1];
        end

        if (k == STEPS - 1) begin : g_last
            assign en[k] = !r_vld[k] || i_ready;
        end else begin : g_mid
            assign en[k] = !r_vld[k] || en[k+1];
        end

        // Shift in three radicand bits, try the next root bit, keep y^2 alongside.
        always_comb begin
            logic [N_W-1:0]   rad;
            logic [STEPS-1:0] y_d;
            logic [Y2_W-1:0]  y2_d;
            logic [RS_W-1:0]  rem_s;
            logic [RS_W-1:0]  trial;
            for (int l = 0; l < 3; l++) begin
                rad   = {{(N_W - TRI_W - 32){1'b0}}, a_src[l], 32'd0};
                y_d   = {a_y[l][STEPS-2:0], 1'b0};
                y2_d  = {a_y2[l][Y2_W-3:0], 2'b00};
                rem_s = {a_rem[l], rad[HI -: 3]};
                trial = (RS_W'(y2_d) << 1) + RS_W'(y2_d)
                      + (RS_W'(y_d) << 1) + RS_W'(y_d) + RS_W'(1);
                if (rem_s >= trial) begin
                    n_rem[l] = REM_W'(rem_s - trial);
                    n_y[l]   = y_d | STEPS'(1);
                    n_y2[l]  = y2_d + (Y2_W'(y_d) << 1) + Y2_W'(1);
                end else begin
                    n_rem[l] = REM_W'(rem_s);
                    n_y[l]   = y_d;
                    n_y2[l]  = y2_d;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en[k]) begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_src[k] <= a_src;
                r_y[k]   <= n_y;
                r_y2[k]  <= n_y2;
                r_rem[k] <= n_rem;
                r_sb[k]  <= a_sb;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_y[STEPS-1];
    assign o_sb    = r_sb[STEPS-1];

endmodule
